// ===== rtl/core/apq_pkg.sv =====
// shared types, sizes and codes for the array priority queue
package apq_pkg;

  localparam int CAPACITY = 8;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int VAL_W    = 32;
  localparam int PRI_W    = 8;
  localparam int CODE_W   = 2;
  localparam int IN_W     = CODE_W + VAL_W + PRI_W;
  localparam int TDATA_W  = ((IN_W + 7) / 8) * 8;

  typedef enum logic [CODE_W-1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_PEEK   = 2'd2
  } opcode_e;

  typedef enum logic [CODE_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // commands from the controller to the datapath
  typedef struct packed {
    logic    load_in;
    logic    insert;
    logic    set_res;
    status_e res_code;
    logic    scan_init;
    logic    scan_step;
    logic    take_top;
    logic    shift_step;
    logic    shrink;
    logic    load_out;
  } apq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic [CODE_W-1:0] op;
    logic              full;
    logic              empty;
    logic              scan_more;
    logic              shift_more;
    logic              out_free;
  } apq_sts_t;

endpackage

// ===== rtl/core/apq_dpath.sv =====
// entry store, scan and compaction registers and the result register
module apq_dpath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  apq_pkg::apq_cmd_t          cmd_i,
  output apq_pkg::apq_sts_t          sts_o,
  input  logic [apq_pkg::TDATA_W-1:0] in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output logic [apq_pkg::TDATA_W-1:0] out_data_o
);
  import apq_pkg::*;

  localparam int ENT_W = VAL_W + PRI_W;

  logic [ENT_W-1:0]  store_q [CAPACITY];

  logic [CODE_W-1:0] op_q;
  logic [VAL_W-1:0]  val_q;
  logic [PRI_W-1:0]  pri_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [CNT_W-1:0]  k_q;
  logic [CNT_W-1:0]  best_idx_q;
  logic [PRI_W-1:0]  best_pri_q;
  logic [VAL_W-1:0]  best_val_q;
  logic [CODE_W-1:0] res_status_q;
  logic [VAL_W-1:0]  res_removed_q;
  logic [PRI_W-1:0]  res_top_q;
  logic              out_valid_q;
  logic [IN_W-1:0]   out_data_q;

  logic [CNT_W:0]    k_next;
  logic [CNT_W-1:0]  rd_addr;
  logic [ENT_W-1:0]  rd_ent;
  logic [ENT_W-1:0]  head_ent;

  // shared read port: scan reads at k, compaction reads the entry after k; entry 0 is read apart for scan start
  assign k_next   = {1'b0, k_q} + 1'b1;
  assign rd_addr  = cmd_i.shift_step ? k_next[CNT_W-1:0] : k_q;
  assign rd_ent   = store_q[rd_addr[IDX_W-1:0]];
  assign head_ent = store_q[0];

  // status toward the controller
  assign sts_o.op         = op_q;
  assign sts_o.full       = (cnt_q == CNT_W'(CAPACITY));
  assign sts_o.empty      = (cnt_q == '0);
  assign sts_o.scan_more  = (k_q < cnt_q);
  assign sts_o.shift_more = (k_next < {1'b0, cnt_q});
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  // entry store, one write a cycle
  always_ff @(posedge clk_i) begin
    if (cmd_i.insert) begin
      store_q[cnt_q[IDX_W-1:0]] <= {pri_q, val_q};
    end else if (cmd_i.shift_step) begin
      store_q[k_q[IDX_W-1:0]] <= rd_ent;
    end
  end

  // input capture, scan and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      op_q  <= in_data_i[CODE_W-1:0];
      val_q <= in_data_i[CODE_W+VAL_W-1:CODE_W];
      pri_q <= in_data_i[IN_W-1:CODE_W+VAL_W];
    end
    if (cmd_i.scan_init) begin
      best_idx_q <= '0;
      best_val_q <= head_ent[VAL_W-1:0];
      best_pri_q <= head_ent[ENT_W-1:VAL_W];
    end else if (cmd_i.scan_step && (rd_ent[ENT_W-1:VAL_W] > best_pri_q)) begin
      best_idx_q <= k_q;
      best_val_q <= rd_ent[VAL_W-1:0];
      best_pri_q <= rd_ent[ENT_W-1:VAL_W];
    end
    if (cmd_i.set_res) begin
      res_status_q  <= cmd_i.res_code;
      res_removed_q <= '0;
      res_top_q     <= '0;
    end else if (cmd_i.take_top) begin
      res_status_q  <= ST_OK;
      res_top_q     <= best_pri_q;
      res_removed_q <= (op_q == OP_DELETE) ? best_val_q : '0;
    end
    if (cmd_i.load_out) begin
      out_data_q <= {res_top_q, res_removed_q, res_status_q};
    end
  end

  // count, scan index and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.insert) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.shrink) begin
        cnt_q <= cnt_q - 1'b1;
      end
      if (cmd_i.scan_init) begin
        k_q <= CNT_W'(1);
      end else if (cmd_i.scan_step || cmd_i.shift_step) begin
        k_q <= k_next[CNT_W-1:0];
      end else if (cmd_i.take_top) begin
        k_q <= best_idx_q;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = {{(TDATA_W-IN_W){1'b0}}, out_data_q};

endmodule

// ===== rtl/core/apq_ctrl.sv =====
// operation sequencer for the array priority queue
module apq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  apq_pkg::apq_sts_t  sts_i,
  output apq_pkg::apq_cmd_t  cmd_o
);
  import apq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // command decode and next state
  always_comb begin
    cmd_o    = '0;
    cmd_o.res_code = ST_OK;
    state_d  = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_in = 1'b1;
          state_d       = S_DECODE;
        end
      end
      S_DECODE: begin
        state_d = S_FINISH;
        case (sts_i.op)
          OP_INSERT: begin
            cmd_o.set_res = 1'b1;
            if (sts_i.full) begin
              cmd_o.res_code = ST_FULL;
            end else begin
              cmd_o.insert = 1'b1;
            end
          end
          OP_DELETE, OP_PEEK: begin
            if (sts_i.empty) begin
              cmd_o.set_res  = 1'b1;
              cmd_o.res_code = ST_EMPTY;
            end else begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
          end
          default: begin
            cmd_o.set_res = 1'b1;
          end
        endcase
      end
      S_SCAN: begin
        if (sts_i.scan_more) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          cmd_o.take_top = 1'b1;
          state_d = (sts_i.op == OP_DELETE) ? S_SHIFT : S_FINISH;
        end
      end
      S_SHIFT: begin
        if (sts_i.shift_more) begin
          cmd_o.shift_step = 1'b1;
        end else begin
          cmd_o.shrink = 1'b1;
          state_d      = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/array_priority_queue.sv =====
// array priority queue: unsorted entry store with scan and compaction
// insert, unused opcode or empty/full report pass idle, decode and finish to the output
// peek also scans the stored entries, and delete also compacts those after the removed one,
// both one entry a cycle through the shared store read port
// one item at a time; a finished result waits in the output register
// reset empties the queue and clears the controller and output valid; store contents stay
module array_priority_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // opcode [1:0], item_value [33:2], item_priority [41:34], zero fill
  input  logic [apq_pkg::TDATA_W-1:0] s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // status [1:0], removed_value [33:2], top_priority [41:34], zero fill
  output logic [apq_pkg::TDATA_W-1:0] m_axis_tdata
);
  import apq_pkg::*;

  apq_cmd_t cmd;
  apq_sts_t sts;

  // sequencer
  apq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // store and result path
  apq_dpath u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata)
  );

endmodule
